// ===== sv/lrw_pkg.sv =====
// Shared types and constants for the Langford random walk estimator.
// No dependencies.
`default_nettype none
package lrw_pkg;
   localparam int unsigned MAX_ORDER_DEF = 32;
   localparam logic [5:0] RESET_ORDER = 6'd31;
   localparam logic [63:0] RESET_SEED = 64'd88172645463325252;
   localparam logic [0:0] CSR_ORDER = 1'b0;
   localparam logic [0:0] CSR_SEED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_MOD, ST_FIND, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan_en;
      logic mod_start;
      logic find_en;
      logic place;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic best_zero;
      logic mod_done;
      logic find_done;
      logic walk_done;
   } sts_type;
endpackage
`default_nettype wire

// ===== sv/lrw_if.sv =====
// Valid/ready channel interfaces for the walk estimator.
// Depends on nothing; payload widths are fixed.
`default_nettype none
interface lrw_req_if;
   logic valid;
   logic ready;
   logic start_req;
   modport source (output valid, output start_req, input ready);
   modport sink (input valid, input start_req, output ready);
endinterface

interface lrw_rsp_if;
   logic valid;
   logic ready;
   logic [5:0] value_placed;
   logic [5:0] position;
   logic [5:0] branch_count;
   logic dead_end;
   logic last;
   modport source (output valid, output value_placed, output position,
                   output branch_count, output dead_end, output last, input ready);
   modport sink (input valid, input value_placed, input position,
                 input branch_count, input dead_end, input last, output ready);
endinterface

interface lrw_csr_if;
   logic valid;
   logic ready;
   logic index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/lrw_ctrl.sv =====
// Walk sequencer: steps scan, modulo, pair search and result transfer.
// Depends on lrw_pkg.
`default_nettype none
module lrw_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_fire,
   input  wire lrw_pkg::sts_type sts,
   output lrw_pkg::cmd_type cmd,
   output logic busy,
   output logic out_valid
);
   lrw_pkg::state_type state_ff, state_in;
   logic dead_ff, dead_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrw_pkg::ST_IDLE;
         dead_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dead_ff <= dead_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dead_in = dead_ff;
      cmd = '0;
      out_valid = 1'b0;
      busy = (state_ff != lrw_pkg::ST_IDLE);
      case (state_ff)
         lrw_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd.start = 1'b1;
               state_in = lrw_pkg::ST_SCAN;
            end
         end
         lrw_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) state_in = lrw_pkg::ST_DECIDE;
         end
         lrw_pkg::ST_DECIDE: begin
            if (sts.best_zero) begin
               dead_in = 1'b1;
               state_in = lrw_pkg::ST_OUT;
            end else begin
               dead_in = 1'b0;
               cmd.mod_start = 1'b1;
               state_in = lrw_pkg::ST_MOD;
            end
         end
         lrw_pkg::ST_MOD: begin
            if (sts.mod_done) state_in = lrw_pkg::ST_FIND;
         end
         lrw_pkg::ST_FIND: begin
            cmd.find_en = 1'b1;
            if (sts.find_done) state_in = lrw_pkg::ST_OUT;
         end
         lrw_pkg::ST_OUT: begin
            out_valid = 1'b1;
            if (rsp_fire) begin
               if (dead_ff) begin
                  state_in = lrw_pkg::ST_IDLE;
               end else begin
                  cmd.place = 1'b1;
                  state_in = sts.walk_done ? lrw_pkg::ST_IDLE : lrw_pkg::ST_SCAN;
               end
            end
         end
         default: state_in = lrw_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/lrw_dp.sv =====
// Walk datapath: occupancy, value scan, xorshift, restoring modulo, pair search.
// Depends on lrw_pkg.
`default_nettype none
module lrw_dp #(
   parameter int unsigned MAX_ORDER = lrw_pkg::MAX_ORDER_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lrw_pkg::cmd_type cmd,
   output lrw_pkg::sts_type sts,
   input  wire logic csr_fire,
   input  wire logic csr_index,
   input  wire logic [63:0] csr_data,
   output logic [5:0] value_placed,
   output logic [5:0] position,
   output logic [5:0] branch_count,
   output logic dead_end_flag,
   output logic last_flag
);
   localparam int unsigned SLOTS = 2 * MAX_ORDER;
   localparam logic [5:0] MAX_N = 6'(MAX_ORDER);

   logic [5:0] order_ff;
   logic [63:0] prng_ff;
   logic [SLOTS-1:0] occ_ff;
   logic [MAX_ORDER-1:0] used_ff;
   logic [5:0] n_ff, left_ff;
   logic [5:0] v_ff, p_ff, cnt_ff;
   logic [5:0] best_v_ff, best_c_ff;
   logic have_ff, scan_done_ff;
   logic [5:0] pick_ff, seen_ff, chosen_ff;
   logic find_done_ff;
   logic [63:0] rem_ff, quo_ff;
   logic [6:0] mbit_ff;
   logic mod_busy_ff;

   logic [5:0] n_eff;
   logic [6:0] p2;
   logic pair_ok, pair_free;
   logic [63:0] x1, x2, x3;
   logic [64:0] rsh;
   logic [63:0] rem_sh;
   logic [5:0] cur_v;

   always_comb begin
      n_eff = order_ff;
      if (order_ff < 6'd2) n_eff = 6'd2;
      if (order_ff > MAX_N) n_eff = MAX_N;
   end

   // second slot of pair at p_ff for the value under test
   assign cur_v = cmd.find_en ? best_v_ff : v_ff;
   assign p2 = 7'(p_ff) + 7'(cur_v) + 7'd1;
   assign pair_ok = (p2 < 7'(2 * n_ff));
   assign pair_free = pair_ok && !occ_ff[p_ff[$clog2(SLOTS)-1:0]]
                      && !occ_ff[p2[$clog2(SLOTS)-1:0]];

   assign x1 = prng_ff ^ (prng_ff << 13);
   assign x2 = x1 ^ (x1 >> 7);
   assign x3 = x2 ^ (x2 << 17);

   assign rem_sh = {rem_ff[62:0], quo_ff[63]};
   assign rsh = {1'b0, rem_sh} - {59'd0, best_c_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= lrw_pkg::RESET_ORDER;
         prng_ff <= lrw_pkg::RESET_SEED;
         occ_ff <= '0;
         used_ff <= '0;
         left_ff <= 6'd0;
         scan_done_ff <= 1'b0;
         find_done_ff <= 1'b0;
         mod_busy_ff <= 1'b0;
      end else begin
         scan_done_ff <= 1'b0;
         find_done_ff <= 1'b0;
         if (csr_fire) begin
            if (csr_index == lrw_pkg::CSR_ORDER) order_ff <= csr_data[5:0];
            else prng_ff <= (csr_data != 64'd0) ? csr_data : lrw_pkg::RESET_SEED;
         end
         if (cmd.start) begin
            n_ff <= n_eff;
            left_ff <= n_eff;
            occ_ff <= '0;
            used_ff <= '0;
            v_ff <= 6'd1;
            p_ff <= 6'd0;
            cnt_ff <= 6'd0;
            have_ff <= 1'b0;
         end
         // one (value, position) check per cycle
         if (cmd.scan_en && !scan_done_ff) begin
            if (v_ff > n_ff) begin
               scan_done_ff <= 1'b1;
            end else if (used_ff[5'(v_ff - 6'd1)]) begin
               v_ff <= v_ff + 6'd1;
            end else if (pair_ok) begin
               p_ff <= p_ff + 6'd1;
               if (pair_free) cnt_ff <= cnt_ff + 6'd1;
            end else begin
               p_ff <= 6'd0;
               cnt_ff <= 6'd0;
               v_ff <= v_ff + 6'd1;
               if (!have_ff || cnt_ff < best_c_ff) begin
                  have_ff <= 1'b1;
                  best_c_ff <= cnt_ff;
                  best_v_ff <= v_ff;
                  if (cnt_ff == 6'd0) scan_done_ff <= 1'b1;
               end
            end
         end
         if (cmd.mod_start) begin
            prng_ff <= x3;
            quo_ff <= x3;
            rem_ff <= '0;
            mbit_ff <= 7'd64;
            mod_busy_ff <= 1'b1;
            p_ff <= 6'd0;
            seen_ff <= 6'd0;
         end else if (mod_busy_ff) begin
            if (mbit_ff == 7'd0) begin
               mod_busy_ff <= 1'b0;
               pick_ff <= rem_ff[5:0];
            end else begin
               quo_ff <= {quo_ff[62:0], 1'b0};
               rem_ff <= rsh[64] ? rem_sh : rsh[63:0];
               mbit_ff <= mbit_ff - 7'd1;
            end
         end
         if (cmd.find_en && !find_done_ff) begin
            if (pair_free) begin
               if (seen_ff == pick_ff) begin
                  chosen_ff <= p_ff;
                  find_done_ff <= 1'b1;
               end else begin
                  seen_ff <= seen_ff + 6'd1;
                  p_ff <= p_ff + 6'd1;
               end
            end else begin
               p_ff <= p_ff + 6'd1;
            end
         end
         if (cmd.place) begin
            occ_ff[chosen_ff[$clog2(SLOTS)-1:0]] <= 1'b1;
            occ_ff[$clog2(SLOTS)'(chosen_ff + best_v_ff + 6'd1)] <= 1'b1;
            used_ff[5'(best_v_ff - 6'd1)] <= 1'b1;
            left_ff <= left_ff - 6'd1;
            v_ff <= 6'd1;
            p_ff <= 6'd0;
            cnt_ff <= 6'd0;
            have_ff <= 1'b0;
         end
      end
   end

   assign sts.scan_done = scan_done_ff;
   assign sts.best_zero = (best_c_ff == 6'd0);
   assign sts.mod_done = mod_busy_ff && (mbit_ff == 7'd0);
   assign sts.find_done = find_done_ff;
   assign sts.walk_done = (left_ff == 6'd1);

   always_comb begin
      if (best_c_ff == 6'd0) begin
         value_placed = 6'd0;
         position = 6'd0;
         branch_count = 6'd0;
         dead_end_flag = 1'b1;
         last_flag = 1'b1;
      end else begin
         value_placed = best_v_ff;
         position = chosen_ff;
         branch_count = best_c_ff;
         dead_end_flag = 1'b0;
         last_flag = (left_ff == 6'd1);
      end
   end
endmodule
`default_nettype wire

// ===== sv/langford_random_walk_estimator.sv =====
// Langford random walk estimator: one random root-to-leaf walk per request,
// one result transfer per level. Each level scans the (value, position)
// pairs of unplaced values one per cycle, stopping at a value with no free
// pair (a dead end), else it runs a 64-step restoring modulo and a position
// search. Requests are taken only when idle.
// Depends on lrw_pkg, lrw_if, lrw_ctrl and lrw_dp.
`default_nettype none
module langford_random_walk_estimator #(
   parameter int unsigned MAX_ORDER = lrw_pkg::MAX_ORDER_DEF
) (
   input wire logic clock,
   input wire logic reset,
   lrw_req_if.sink req,
   lrw_rsp_if.source rsp,
   lrw_csr_if.sink csr
);
   lrw_pkg::cmd_type cmd;
   lrw_pkg::sts_type sts;
   logic busy, out_valid, req_fire, rsp_fire;

   assign req.ready = !busy;
   assign req_fire = req.valid && req.ready && req.start_req;
   assign rsp.valid = out_valid;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;

   lrw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
   );

   lrw_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_fire(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .value_placed(rsp.value_placed), .position(rsp.position),
      .branch_count(rsp.branch_count), .dead_end_flag(rsp.dead_end),
      .last_flag(rsp.last)
   );
endmodule
`default_nettype wire

// ===== test/tb_lrw_channels.sv =====
// Testbench-side helpers for the walk estimator channels.
// Self-contained; the channel interfaces themselves come from lrw_if.
`timescale 1ns / 1ps
package tb_lrw_pkg;
   typedef struct packed {
      logic [5:0] value_placed;
      logic [5:0] position;
      logic [5:0] branch_count;
      logic dead_end;
      logic last;
   } step_result_type;
endpackage

// ===== test/tb_langford_random_walk_estimator.sv =====
// Self-checking testbench for langford_random_walk_estimator: random walks of
// the Langford search, predicted in-bench and compared per level result.
// Depends on lrw_pkg, lrw_if, tb_lrw_pkg and the estimator RTL.
`timescale 1ns / 1ps
module tb_langford_random_walk_estimator;
   logic clock = 1'b0;
   logic reset = 1'b1;
   lrw_req_if req ();
   lrw_rsp_if rsp ();
   lrw_csr_if csr ();

   langford_random_walk_estimator dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [5:0] order_reg;
   logic [63:0] walk_rng;
   logic [63:0] occupied;
   logic [31:0] placed_set;
   tb_lrw_pkg::step_result_type level_queue[$];

   int fails = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;

   // order 2 always places value 2 at slot 0, then dead-ends on value 1
   localparam tb_lrw_pkg::step_result_type PLACE_TWO = '{6'd2, 6'd0, 6'd1, 1'b0, 1'b0};
   localparam tb_lrw_pkg::step_result_type DEAD_END = '{6'd0, 6'd0, 6'd0, 1'b1, 1'b1};
   localparam tb_lrw_pkg::step_result_type NO_RESULT = '0;

   function automatic logic [63:0] pair_bits(int p, int v);
      logic [63:0] m;
      m = '0;
      m[p] = 1'b1;
      m[p + v + 1] = 1'b1;
      return m;
   endfunction

   function automatic int count_pairs(int v, int slots);
      int c;
      c = 0;
      for (int p = 0; p + v + 1 < slots; p++)
         if ((occupied & pair_bits(p, v)) == 0) c++;
      return c;
   endfunction

   // Walk one full root-to-leaf path and collect each level's result.
   task automatic predict_walk(ref tb_lrw_pkg::step_result_type q[$]);
      int n, slots, left, best_v, best_c, pick, seen, chosen, c;
      bit have;
      tb_lrw_pkg::step_result_type r;
      n = order_reg;
      if (n < 2) n = 2;
      if (n > 32) n = 32;
      slots = 2 * n;
      occupied = '0;
      placed_set = '0;
      left = n;
      while (left > 0) begin
         have = 0; best_v = 0; best_c = 0;
         for (int v = 1; v <= n; v++) begin
            if (placed_set[v-1]) continue;
            c = count_pairs(v, slots);
            if (!have || c < best_c) begin
               have = 1; best_c = c; best_v = v;
               if (c == 0) break;
            end
         end
         if (best_c == 0) begin
            r = DEAD_END;
            q.push_back(r);
            break;
         end
         walk_rng = walk_rng ^ (walk_rng << 13);
         walk_rng = walk_rng ^ (walk_rng >> 7);
         walk_rng = walk_rng ^ (walk_rng << 17);
         pick = int'(walk_rng % 64'(best_c));
         seen = 0; chosen = 0;
         for (int p = 0; p + best_v + 1 < slots; p++) begin
            if ((occupied & pair_bits(p, best_v)) == 0) begin
               if (seen == pick) begin
                  chosen = p;
                  break;
               end
               seen++;
            end
         end
         occupied |= pair_bits(chosen, best_v);
         placed_set[best_v-1] = 1'b1;
         left--;
         r = '{6'(best_v), 6'(chosen), 6'(best_c), 1'b0, 1'(left == 0)};
         q.push_back(r);
      end
   endtask

   // Hold valid through back-to-back writes; drop it after the final one.
   task automatic write_reg(logic idx, logic [63:0] value, logic more);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      if (!more) csr.valid <= 1'b0;
      if (idx == lrw_pkg::CSR_ORDER) order_reg = value[5:0];
      else walk_rng = (value != 0) ? value : lrw_pkg::RESET_SEED;
   endtask

   task automatic send_walk(logic start, logic typed,
                            tb_lrw_pkg::step_result_type exp_first,
                            tb_lrw_pkg::step_result_type exp_last);
      tb_lrw_pkg::step_result_type walk_q[$];
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.start_req <= start;
      do @(posedge clock); while (!req.ready);
      if (start) begin
         predict_walk(walk_q);
         if (typed) walk_q = '{exp_first, exp_last};
         foreach (walk_q[j]) level_queue.push_back(walk_q[j]);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (level_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // receiver: random stalls, plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      tb_lrw_pkg::step_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.value_placed, rsp.position, rsp.branch_count, rsp.dead_end, rsp.last};
         if (level_queue.size() == 0) begin
            $display("%0t unexpected transfer: actual %p", $time, got);
            fails++;
         end else begin
            want = level_queue.pop_front();
            if (got !== want) begin
               $display("%0t expected %p actual %p", $time, want, got);
               fails++;
            end
         end
      end
   end

   // directed rows: order register value, seed, start bit, typed results
   typedef struct {
      logic [5:0] order;
      logic [63:0] seed;
      logic start;
      logic typed;
      tb_lrw_pkg::step_result_type exp_first;
      tb_lrw_pkg::step_result_type exp_last;
   } walk_row_type;

   walk_row_type rows[] = '{
      '{6'd31, lrw_pkg::RESET_SEED, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd2, 64'd1, 1'b1, 1'b1, PLACE_TWO, DEAD_END},
      '{6'd0, 64'd0, 1'b1, 1'b1, PLACE_TWO, DEAD_END},
      '{6'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, PLACE_TWO, DEAD_END},
      '{6'd3, 64'h8000_0000_0000_0000, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd4, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd7, 64'd12345, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd8, 64'hDEAD_BEEF_0000_0001, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd32, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd63, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd5, 64'd7, 1'b0, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd11, 64'h0000_0001_0000_0000, 1'b1, 1'b0, NO_RESULT, NO_RESULT},
      '{6'd12, 64'hAAAA_5555_AAAA_5555, 1'b1, 1'b0, NO_RESULT, NO_RESULT}
   };

   initial begin
      int phase;
      req.valid = 1'b0;
      req.start_req = 1'b0;
      csr.valid = 1'b0;
      csr.index = lrw_pkg::CSR_ORDER;
      csr.data = '0;
      order_reg = lrw_pkg::RESET_ORDER;
      walk_rng = lrw_pkg::RESET_SEED;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Check the reset defaults first, without touching the registers.
      send_walk(1'b1, 1'b0, NO_RESULT, NO_RESULT);
      drain();
      foreach (rows[i]) begin
         write_reg(lrw_pkg::CSR_ORDER, 64'(rows[i].order), 1'b1);
         write_reg(lrw_pkg::CSR_SEED, rows[i].seed, 1'b0);
         send_walk(rows[i].start, rows[i].typed, rows[i].exp_first, rows[i].exp_last);
         send_walk(1'b1, 1'b0, NO_RESULT, NO_RESULT);
         drain();
      end

      for (int k = 0; k < 270; k++) begin
         phase = (k / 30) % 4;
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 64 : 12) : 0;
         recv_stall_pct = (phase == 2) ? 64 : ((phase == 3) ? 12 : 0);
         if (k % 15 == 0) begin
            drain();
            // mostly small orders keep the run short; sometimes any order up to 63
            write_reg(lrw_pkg::CSR_ORDER, ($urandom_range(9) == 0) ?
                      64'($urandom_range(63)) : 64'($urandom_range(12)), 1'b1);
            write_reg(lrw_pkg::CSR_SEED, {$urandom, $urandom}, 1'b0);
         end
         if (k == 100) hold_off <= 3000;
         send_walk($urandom_range(19) != 0, 1'b0, NO_RESULT, NO_RESULT);
      end
      drain();
      if (fails == 0)
         $display("langford_random_walk_estimator: match");
      else
         $display("langford_random_walk_estimator: mismatch");
      $finish;
   end

   initial begin
      #1s;
      $display("langford_random_walk_estimator: mismatch");
      $finish;
   end
endmodule

// ===== langford_random_walk_estimator.f =====
sv/lrw_pkg.sv
sv/lrw_if.sv
sv/lrw_ctrl.sv
sv/lrw_dp.sv
sv/langford_random_walk_estimator.sv
test/tb_lrw_channels.sv
test/tb_langford_random_walk_estimator.sv
